@@ design/afjc_pkg.sv @@
// afjc_pkg: shared types and codes for the auger feed with jam clearing block
// used by afjc_step and auger_feed_with_jam_clearing; no dependencies
`default_nettype none

package afjc_pkg;

  // feed sequence phases
  localparam logic [2:0] FP_IDLE  = 3'd0;
  localparam logic [2:0] FP_INIT  = 3'd1;
  localparam logic [2:0] FP_ACT   = 3'd2;
  localparam logic [2:0] FP_FILL  = 3'd3;
  localparam logic [2:0] FP_WAIT  = 3'd4;
  localparam logic [2:0] FP_CLEAR = 3'd5;
  localparam logic [2:0] FP_LOADF = 3'd6;
  localparam logic [2:0] FP_JAMF  = 3'd7;

  // jam clearing phases
  localparam logic [2:0] CP_INIT  = 3'd0;
  localparam logic [2:0] CP_REV   = 3'd1;
  localparam logic [2:0] CP_REVP  = 3'd2;
  localparam logic [2:0] CP_FWD   = 3'd3;
  localparam logic [2:0] CP_FWDP  = 3'd4;
  localparam logic [2:0] CP_FAULT = 3'd5;

  // relay latch bits
  localparam logic [2:0] RL_NONE = 3'b000;
  localparam logic [2:0] RL_FWD  = 3'b001;
  localparam logic [2:0] RL_REV  = 3'b010;
  localparam logic [2:0] RL_FEED = 3'b100;

  // fault codes
  localparam logic [1:0] FLT_NONE = 2'd0;
  localparam logic [1:0] FLT_LOAD = 2'd1;
  localparam logic [1:0] FLT_JAM  = 2'd2;

  // clear step outcomes
  localparam logic [1:0] CR_NONE = 2'd0;
  localparam logic [1:0] CR_TURN = 2'd1;
  localparam logic [1:0] CR_JAM  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_TURN_TIMEOUT   = 3'd0;
  localparam logic [2:0] CFG_REFILL_TIMEOUT = 3'd1;
  localparam logic [2:0] CFG_REVERSE        = 3'd2;
  localparam logic [2:0] CFG_PAUSE          = 3'd3;
  localparam logic [2:0] CFG_FORWARD        = 3'd4;
  localparam logic [2:0] CFG_MAX_TRIES      = 3'd5;

  typedef struct packed {
    logic [15:0] turn_timeout;
    logic [15:0] refill_timeout;
    logic [15:0] reverse_len;
    logic [15:0] pause_len;
    logic [15:0] forward_len;
    logic [2:0]  max_tries;
  } cfg_t;

  typedef struct packed {
    logic [2:0] feed_phase;
    logic [2:0] clear_phase;
    logic [7:0] turn_count;
    logic [7:0] feed_snap;
    logic [7:0] clear_snap;
    logic [2:0] rev_tries;
    logic [2:0] relays;
  } state_t;

  typedef struct packed {
    logic       screw_forward;
    logic       screw_reverse;
    logic       feeder_on;
    logic       done_res;
    logic [1:0] fault;
  } res_t;

endpackage

`default_nettype wire

@@ design/afjc_step.sv @@
// afjc_step: next-state and result logic for one tick or start word
// depends on afjc_pkg
`default_nettype none

module afjc_step #(
  parameter int TIMER_WIDTH = 16
) (
  input  wire afjc_pkg::state_t        st,
  input  wire logic [TIMER_WIDTH-1:0]  feed_tmr,
  input  wire logic [TIMER_WIDTH-1:0]  clear_tmr,
  input  wire afjc_pkg::cfg_t          cfg,
  input  wire logic                    cmd,
  input  wire logic                    fuel_ok,
  input  wire logic                    turn_pulse,
  input  wire logic [7:0]              target_turns,
  output afjc_pkg::state_t             st_nxt,
  output logic [TIMER_WIDTH-1:0]       feed_tmr_nxt,
  output logic [TIMER_WIDTH-1:0]       clear_tmr_nxt,
  output afjc_pkg::res_t               res
);

  localparam logic [32:0] TMR_MAX = (33'd1 << TIMER_WIDTH) - 33'd1;

  // loads saturate at the timer range
  function automatic logic [TIMER_WIDTH-1:0] tload(input logic [15:0] v);
    logic [32:0] v33;
    v33 = {17'd0, v};
    if (v33 > TMR_MAX) return TMR_MAX[TIMER_WIDTH-1:0];
    else               return v33[TIMER_WIDTH-1:0];
  endfunction

  logic       fexp;
  logic       cexp;
  logic [1:0] cres;

  always_comb begin
    st_nxt        = st;
    feed_tmr_nxt  = feed_tmr;
    clear_tmr_nxt = clear_tmr;
    res           = '0;
    fexp          = 1'b0;
    cexp          = 1'b0;
    cres          = afjc_pkg::CR_NONE;

    if (cmd) begin
      st_nxt.feed_phase  = afjc_pkg::FP_INIT;
      st_nxt.clear_phase = afjc_pkg::CP_INIT;
      st_nxt.relays      = afjc_pkg::RL_NONE;
    end else begin
      if (turn_pulse && st.turn_count != 8'hFF)
        st_nxt.turn_count = st.turn_count + 8'd1;
      feed_tmr_nxt  = (feed_tmr != '0) ? feed_tmr - 1'b1 : '0;
      clear_tmr_nxt = (clear_tmr != '0) ? clear_tmr - 1'b1 : '0;
      fexp = (feed_tmr_nxt == '0);
      cexp = (clear_tmr_nxt == '0);

      case (st.feed_phase)
        afjc_pkg::FP_INIT: begin
          st_nxt.turn_count = 8'd0;
          st_nxt.feed_snap  = 8'd0;
          feed_tmr_nxt      = tload(cfg.turn_timeout);
          st_nxt.feed_phase = afjc_pkg::FP_ACT;
          st_nxt.relays     = (st.relays & afjc_pkg::RL_FEED) | afjc_pkg::RL_FWD;
        end
        afjc_pkg::FP_ACT: begin
          if (!fuel_ok) begin
            feed_tmr_nxt      = tload(cfg.refill_timeout);
            st_nxt.feed_phase = afjc_pkg::FP_FILL;
          end else begin
            st_nxt.relays = afjc_pkg::RL_FWD;
            if (fexp)
              st_nxt.feed_phase = afjc_pkg::FP_CLEAR;
            if (st.feed_snap != st_nxt.turn_count)
              feed_tmr_nxt = tload(cfg.turn_timeout);
            st_nxt.feed_snap = st_nxt.turn_count;
            if (st_nxt.turn_count >= target_turns) begin
              st_nxt.feed_phase = afjc_pkg::FP_IDLE;
              st_nxt.relays     = afjc_pkg::RL_NONE;
              res.done_res      = 1'b1;
            end
          end
        end
        afjc_pkg::FP_FILL: begin
          st_nxt.relays = afjc_pkg::RL_FEED;
          if (fuel_ok) begin
            feed_tmr_nxt      = tload(cfg.turn_timeout);
            st_nxt.feed_phase = afjc_pkg::FP_WAIT;
          end else if (fexp) begin
            st_nxt.feed_phase = afjc_pkg::FP_LOADF;
            st_nxt.relays     = afjc_pkg::RL_NONE;
            res.done_res      = 1'b1;
          end
        end
        afjc_pkg::FP_WAIT: begin
          st_nxt.relays = afjc_pkg::RL_FEED;
          if (fexp)
            st_nxt.feed_phase = afjc_pkg::FP_ACT;
        end
        afjc_pkg::FP_CLEAR: begin
          case (st.clear_phase)
            afjc_pkg::CP_INIT: begin
              st_nxt.rev_tries   = 3'd0;
              st_nxt.clear_snap  = st_nxt.turn_count;
              clear_tmr_nxt      = tload(cfg.reverse_len);
              st_nxt.clear_phase = afjc_pkg::CP_REV;
              st_nxt.relays = (st.relays & afjc_pkg::RL_FEED) | afjc_pkg::RL_REV;
            end
            afjc_pkg::CP_REV: begin
              st_nxt.relays = (st.relays & afjc_pkg::RL_FEED) | afjc_pkg::RL_REV;
              if (cexp) begin
                st_nxt.clear_snap = st_nxt.turn_count;
                clear_tmr_nxt     = tload(cfg.pause_len);
                st_nxt.relays     = st.relays & afjc_pkg::RL_FEED;
                if (st.rev_tries >= cfg.max_tries) begin
                  st_nxt.clear_phase = afjc_pkg::CP_FAULT;
                end else begin
                  st_nxt.clear_phase = afjc_pkg::CP_REVP;
                  st_nxt.rev_tries   = st.rev_tries + 3'd1;
                end
              end
            end
            afjc_pkg::CP_REVP: begin
              st_nxt.relays = st.relays & afjc_pkg::RL_FEED;
              if (cexp) begin
                clear_tmr_nxt      = tload(cfg.forward_len);
                st_nxt.clear_phase = afjc_pkg::CP_FWD;
                st_nxt.relays = (st.relays & afjc_pkg::RL_FEED) | afjc_pkg::RL_FWD;
              end
            end
            afjc_pkg::CP_FWD: begin
              st_nxt.relays = (st.relays & afjc_pkg::RL_FEED) | afjc_pkg::RL_FWD;
              if (cexp) begin
                clear_tmr_nxt      = tload(cfg.pause_len);
                st_nxt.clear_phase = afjc_pkg::CP_FWDP;
                st_nxt.relays      = st.relays & afjc_pkg::RL_FEED;
              end
              // a turn during the forward run ends clearing
              if (st.clear_snap != st_nxt.turn_count) begin
                st_nxt.clear_phase = afjc_pkg::CP_INIT;
                cres               = afjc_pkg::CR_TURN;
              end else begin
                st_nxt.clear_snap = st_nxt.turn_count;
              end
            end
            afjc_pkg::CP_FWDP: begin
              st_nxt.relays = st.relays & afjc_pkg::RL_FEED;
              if (cexp) begin
                clear_tmr_nxt      = tload(cfg.reverse_len);
                st_nxt.clear_phase = afjc_pkg::CP_REV;
                st_nxt.relays = (st.relays & afjc_pkg::RL_FEED) | afjc_pkg::RL_REV;
              end
            end
            default: begin
              st_nxt.clear_phase = afjc_pkg::CP_INIT;
              cres               = afjc_pkg::CR_JAM;
            end
          endcase
          if (cres == afjc_pkg::CR_TURN) begin
            st_nxt.feed_phase = afjc_pkg::FP_ACT;
            feed_tmr_nxt      = tload(cfg.turn_timeout);
          end else if (cres == afjc_pkg::CR_JAM) begin
            st_nxt.feed_phase = afjc_pkg::FP_JAMF;
            st_nxt.relays     = afjc_pkg::RL_NONE;
          end
        end
        default: begin
          st_nxt.relays = afjc_pkg::RL_NONE;
        end
      endcase

      if (st_nxt.feed_phase == afjc_pkg::FP_LOADF)
        res.fault = afjc_pkg::FLT_LOAD;
      else if (st_nxt.feed_phase == afjc_pkg::FP_JAMF)
        res.fault = afjc_pkg::FLT_JAM;
    end

    res.screw_forward = |(st_nxt.relays & afjc_pkg::RL_FWD);
    res.screw_reverse = |(st_nxt.relays & afjc_pkg::RL_REV);
    res.feeder_on     = |(st_nxt.relays & afjc_pkg::RL_FEED);
  end

endmodule

`default_nettype wire

@@ design/auger_feed_with_jam_clearing.sv @@
// auger_feed_with_jam_clearing: top level with config registers, state and result register
// depends on afjc_pkg and afjc_step
`default_nettype none

// Auger feed controller with jam clearing. Each input word is a tick (cmd 0) or a
// start command (cmd 1); every word yields one result word holding the relay
// states, done and fault. A word is accepted whenever the result register is empty
// or being taken, so with out_ready high one word per cycle is sustained; its
// result appears in the output register on the next cycle. The whole step runs
// in one pass through afjc_step between the state and result registers, so only
// out_ready sets the rate. Configuration writes are taken in every cycle.
module auger_feed_with_jam_clearing #(
  parameter int TIMER_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_cmd,
  input  wire logic        in_fuel_ok,
  input  wire logic        in_turn_pulse,
  input  wire logic [7:0]  in_target_turns,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_screw_forward,
  output logic             out_screw_reverse,
  output logic             out_feeder_on,
  output logic             out_done_res,
  output logic [1:0]       out_fault,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  afjc_pkg::cfg_t   cfg_r;
  afjc_pkg::state_t st_r;
  afjc_pkg::state_t st_nxt;
  afjc_pkg::res_t   res_nxt;
  afjc_pkg::res_t   res_r;
  logic [TIMER_WIDTH-1:0] feed_tmr_r;
  logic [TIMER_WIDTH-1:0] feed_tmr_nxt;
  logic [TIMER_WIDTH-1:0] clear_tmr_r;
  logic [TIMER_WIDTH-1:0] clear_tmr_nxt;
  logic out_valid_r;
  logic in_acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.turn_timeout   <= 16'd400;
      cfg_r.refill_timeout <= 16'd1000;
      cfg_r.reverse_len    <= 16'd200;
      cfg_r.pause_len      <= 16'd100;
      cfg_r.forward_len    <= 16'd400;
      cfg_r.max_tries      <= 3'd3;
    end else if (cfg_valid) begin
      case (cfg_index)
        afjc_pkg::CFG_TURN_TIMEOUT:   cfg_r.turn_timeout   <= cfg_data;
        afjc_pkg::CFG_REFILL_TIMEOUT: cfg_r.refill_timeout <= cfg_data;
        afjc_pkg::CFG_REVERSE:        cfg_r.reverse_len    <= cfg_data;
        afjc_pkg::CFG_PAUSE:          cfg_r.pause_len      <= cfg_data;
        afjc_pkg::CFG_FORWARD:        cfg_r.forward_len    <= cfg_data;
        afjc_pkg::CFG_MAX_TRIES:      cfg_r.max_tries      <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  afjc_step #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_step (
    .st            (st_r),
    .feed_tmr      (feed_tmr_r),
    .clear_tmr     (clear_tmr_r),
    .cfg           (cfg_r),
    .cmd           (in_cmd),
    .fuel_ok       (in_fuel_ok),
    .turn_pulse    (in_turn_pulse),
    .target_turns  (in_target_turns),
    .st_nxt        (st_nxt),
    .feed_tmr_nxt  (feed_tmr_nxt),
    .clear_tmr_nxt (clear_tmr_nxt),
    .res           (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.feed_phase  <= afjc_pkg::FP_IDLE;
      st_r.clear_phase <= afjc_pkg::CP_INIT;
      st_r.turn_count  <= 8'd0;
      st_r.feed_snap   <= 8'd0;
      st_r.clear_snap  <= 8'd0;
      st_r.rev_tries   <= 3'd0;
      st_r.relays      <= afjc_pkg::RL_NONE;
      feed_tmr_r       <= '0;
      clear_tmr_r      <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (in_acc) begin
        st_r        <= st_nxt;
        feed_tmr_r  <= feed_tmr_nxt;
        clear_tmr_r <= clear_tmr_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc)
      res_r <= res_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_screw_forward = res_r.screw_forward;
  assign out_screw_reverse = res_r.screw_reverse;
  assign out_feeder_on     = res_r.feeder_on;
  assign out_done_res      = res_r.done_res;
  assign out_fault         = res_r.fault;

`ifndef SYNTH
  a_no_fwd_rev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_screw_forward && out_screw_reverse))
    else $error("forward and reverse relays both on");

  a_fault_relays_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fault != afjc_pkg::FLT_NONE) |->
      (!out_screw_forward && !out_screw_reverse && !out_feeder_on))
    else $error("relay on while faulted");

  a_done_relays_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_res) |->
      (!out_screw_forward && !out_screw_reverse && !out_feeder_on &&
       out_fault != afjc_pkg::FLT_JAM))
    else $error("done with relay on or jam fault");

  a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd) |=>
      (out_valid_r && !out_done_res && out_fault == afjc_pkg::FLT_NONE &&
       st_r.feed_phase == afjc_pkg::FP_INIT))
    else $error("start command result not clean");

  a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_fault != 2'd3))
    else $error("illegal fault code");
`endif

endmodule

`default_nettype wire

@@ dv/auger_feed_with_jam_clearing_test.sv @@
// auger_feed_with_jam_clearing_test: self-checking bench for the auger feed controller
// scoreboard class predicts every result word; plain tasks drive input, config and output
// depends on afjc_pkg and auger_feed_with_jam_clearing
`timescale 1ns / 100ps

class auger_scoreboard;
  logic [15:0] turn_to, refill_to, rev_len, pause_len, fwd_len;
  logic [2:0]  max_tries;
  logic [2:0]  feed_ph, clr_ph, tries, relays;
  logic [7:0]  turns, feed_snap, clr_snap;
  logic [15:0] feed_tmr, clr_tmr;
  afjc_pkg::res_t want_q[$];
  int unsigned errors;

  function new();
    turn_to   = 16'd400;
    refill_to = 16'd1000;
    rev_len   = 16'd200;
    pause_len = 16'd100;
    fwd_len   = 16'd400;
    max_tries = 3'd3;
    feed_ph   = afjc_pkg::FP_IDLE;
    clr_ph    = afjc_pkg::CP_INIT;
    tries     = 3'd0;
    relays    = afjc_pkg::RL_NONE;
    turns     = 8'd0;
    feed_snap = 8'd0;
    clr_snap  = 8'd0;
    feed_tmr  = 16'd0;
    clr_tmr   = 16'd0;
    errors    = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      afjc_pkg::CFG_TURN_TIMEOUT:   turn_to = val;
      afjc_pkg::CFG_REFILL_TIMEOUT: refill_to = val;
      afjc_pkg::CFG_REVERSE:        rev_len = val;
      afjc_pkg::CFG_PAUSE:          pause_len = val;
      afjc_pkg::CFG_FORWARD:        fwd_len = val;
      afjc_pkg::CFG_MAX_TRIES:      max_tries = val[2:0];
      default: ;
    endcase
  endfunction

  function bit resting();
    return (feed_ph == afjc_pkg::FP_IDLE) || (feed_ph == afjc_pkg::FP_LOADF) ||
           (feed_ph == afjc_pkg::FP_JAMF);
  endfunction

  function int pending();
    return want_q.size();
  endfunction

  // one tick of the reverse / pause / forward / pause cycle
  function logic [1:0] clear_cycle();
    logic expired;
    expired = (clr_tmr == 16'd0);
    case (clr_ph)
      afjc_pkg::CP_INIT: begin
        tries    = 3'd0;
        clr_snap = turns;
        clr_tmr  = rev_len;
        clr_ph   = afjc_pkg::CP_REV;
        relays   = (relays & afjc_pkg::RL_FEED) | afjc_pkg::RL_REV;
      end
      afjc_pkg::CP_REV: begin
        relays = (relays & afjc_pkg::RL_FEED) | afjc_pkg::RL_REV;
        if (expired) begin
          clr_snap = turns;
          clr_tmr  = pause_len;
          clr_ph   = afjc_pkg::CP_REVP;
          relays   = relays & afjc_pkg::RL_FEED;
          if (tries >= max_tries) begin
            clr_ph = afjc_pkg::CP_FAULT;
          end else begin
            tries = tries + 3'd1;
          end
        end
      end
      afjc_pkg::CP_REVP: begin
        relays = relays & afjc_pkg::RL_FEED;
        if (expired) begin
          clr_tmr = fwd_len;
          clr_ph  = afjc_pkg::CP_FWD;
          relays  = (relays & afjc_pkg::RL_FEED) | afjc_pkg::RL_FWD;
        end
      end
      afjc_pkg::CP_FWD: begin
        relays = (relays & afjc_pkg::RL_FEED) | afjc_pkg::RL_FWD;
        if (expired) begin
          clr_tmr = pause_len;
          clr_ph  = afjc_pkg::CP_FWDP;
          relays  = relays & afjc_pkg::RL_FEED;
        end
        // a turn during the forward run ends clearing
        if (clr_snap != turns) begin
          clr_ph = afjc_pkg::CP_INIT;
          return afjc_pkg::CR_TURN;
        end
        clr_snap = turns;
      end
      afjc_pkg::CP_FWDP: begin
        relays = relays & afjc_pkg::RL_FEED;
        if (expired) begin
          clr_tmr = rev_len;
          clr_ph  = afjc_pkg::CP_REV;
          relays  = (relays & afjc_pkg::RL_FEED) | afjc_pkg::RL_REV;
        end
      end
      default: begin
        clr_ph = afjc_pkg::CP_INIT;
        return afjc_pkg::CR_JAM;
      end
    endcase
    return afjc_pkg::CR_NONE;
  endfunction

  // notes an accepted input word; returns 1 when the word does real work
  function bit take_word(bit cmd, bit fuel, bit turn, logic [7:0] target);
    afjc_pkg::res_t want;
    logic       expired;
    logic       fin;
    logic [1:0] flt;
    logic [1:0] cr;
    bit         live;
    live = cmd || !resting();
    fin  = 1'b0;
    flt  = afjc_pkg::FLT_NONE;
    if (cmd) begin
      feed_ph = afjc_pkg::FP_INIT;
      clr_ph  = afjc_pkg::CP_INIT;
      relays  = afjc_pkg::RL_NONE;
    end else begin
      if (turn && turns != 8'hFF) turns = turns + 8'd1;
      feed_tmr = (feed_tmr != 16'd0) ? feed_tmr - 16'd1 : 16'd0;
      clr_tmr  = (clr_tmr != 16'd0) ? clr_tmr - 16'd1 : 16'd0;
      expired  = (feed_tmr == 16'd0);
      case (feed_ph)
        afjc_pkg::FP_INIT: begin
          turns     = 8'd0;
          feed_snap = 8'd0;
          feed_tmr  = turn_to;
          feed_ph   = afjc_pkg::FP_ACT;
          relays    = (relays & afjc_pkg::RL_FEED) | afjc_pkg::RL_FWD;
        end
        afjc_pkg::FP_ACT: begin
          if (!fuel) begin
            // relays left as they were
            feed_tmr = refill_to;
            feed_ph  = afjc_pkg::FP_FILL;
          end else begin
            relays = afjc_pkg::RL_FWD;
            if (expired) feed_ph = afjc_pkg::FP_CLEAR;
            if (feed_snap != turns) feed_tmr = turn_to;
            feed_snap = turns;
            if (turns >= target) begin
              feed_ph = afjc_pkg::FP_IDLE;
              relays  = afjc_pkg::RL_NONE;
              fin     = 1'b1;
            end
          end
        end
        afjc_pkg::FP_FILL: begin
          relays = afjc_pkg::RL_FEED;
          if (fuel) begin
            feed_tmr = turn_to;
            feed_ph  = afjc_pkg::FP_WAIT;
          end else if (expired) begin
            feed_ph = afjc_pkg::FP_LOADF;
            relays  = afjc_pkg::RL_NONE;
            fin     = 1'b1;
          end
        end
        afjc_pkg::FP_WAIT: begin
          relays = afjc_pkg::RL_FEED;
          if (expired) feed_ph = afjc_pkg::FP_ACT;
        end
        afjc_pkg::FP_CLEAR: begin
          cr = clear_cycle();
          if (cr == afjc_pkg::CR_TURN) begin
            feed_ph  = afjc_pkg::FP_ACT;
            feed_tmr = turn_to;
          end else if (cr == afjc_pkg::CR_JAM) begin
            feed_ph = afjc_pkg::FP_JAMF;
            relays  = afjc_pkg::RL_NONE;
          end
        end
        default: relays = afjc_pkg::RL_NONE;
      endcase
      if (feed_ph == afjc_pkg::FP_LOADF) flt = afjc_pkg::FLT_LOAD;
      else if (feed_ph == afjc_pkg::FP_JAMF) flt = afjc_pkg::FLT_JAM;
    end
    want.screw_forward = (relays & afjc_pkg::RL_FWD) != afjc_pkg::RL_NONE;
    want.screw_reverse = (relays & afjc_pkg::RL_REV) != afjc_pkg::RL_NONE;
    want.feeder_on     = (relays & afjc_pkg::RL_FEED) != afjc_pkg::RL_NONE;
    want.done_res      = fin;
    want.fault         = flt;
    want_q.push_back(want);
    return live;
  endfunction

  function void check_word(afjc_pkg::res_t got);
    afjc_pkg::res_t want;
    bit   bad;
    if (want_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("result word with nothing expected:",
                 " fwd %0b rev %0b feed %0b done %0b fault %0d",
                 got.screw_forward, got.screw_reverse, got.feeder_on, got.done_res, got.fault);
      return;
    end
    want = want_q.pop_front();
    bad = (got.screw_forward !== want.screw_forward) ||
          (got.screw_reverse !== want.screw_reverse) ||
          (got.feeder_on !== want.feeder_on) ||
          (got.done_res !== want.done_res) ||
          (got.fault !== want.fault);
    if (bad) begin
      errors++;
      if (errors <= 10)
        $display("mismatch at %0t: want fwd %0b rev %0b feed %0b done %0b fault %0d,",
                 $realtime, want.screw_forward, want.screw_reverse, want.feeder_on,
                 want.done_res, want.fault,
                 " got fwd %0b rev %0b feed %0b done %0b fault %0d",
                 got.screw_forward, got.screw_reverse,
                 got.feeder_on, got.done_res, got.fault);
    end
  endfunction
endclass

module auger_feed_with_jam_clearing_test;
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_cmd;
  logic        in_fuel_ok;
  logic        in_turn_pulse;
  logic [7:0]  in_target_turns;
  logic        out_valid;
  logic        out_ready;
  logic        out_screw_forward;
  logic        out_screw_reverse;
  logic        out_feeder_on;
  logic        out_done_res;
  logic [1:0]  out_fault;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  auger_scoreboard sb;
  int unsigned     live_words;
  int unsigned     tx_idle_pct;
  int unsigned     rx_idle_pct;
  int unsigned     rx_hold_req;

  auger_feed_with_jam_clearing i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_fuel_ok       (in_fuel_ok),
    .in_turn_pulse    (in_turn_pulse),
    .in_target_turns  (in_target_turns),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_screw_forward(out_screw_forward),
    .out_screw_reverse(out_screw_reverse),
    .out_feeder_on    (out_feeder_on),
    .out_done_res     (out_done_res),
    .out_fault        (out_fault),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stalls plus an occasional long hold-off
  initial begin : rx_side
    int unsigned hold;
    hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req != 0) begin
        hold = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold != 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_word({out_screw_forward, out_screw_reverse, out_feeder_on,
                     out_done_res, out_fault});
  end

  // valid stays up between back-to-back words
  task automatic send_word(bit cmd, bit fuel, bit turn, logic [7:0] target);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_fuel_ok      <= fuel;
    in_turn_pulse   <= turn;
    in_target_turns <= target;
    do @(posedge clk); while (!in_ready);
    if (sb.take_word(cmd, fuel, turn, target)) live_words++;
  endtask

  // stop offering and wait for every expected word plus the pipeline tail
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic write_regs(logic [15:0] t_turn, logic [15:0] t_refill, logic [15:0] t_rev,
                            logic [15:0] t_pause, logic [15:0] t_fwd, logic [2:0] n_tries);
    write_reg(afjc_pkg::CFG_TURN_TIMEOUT, t_turn);
    write_reg(afjc_pkg::CFG_REFILL_TIMEOUT, t_refill);
    write_reg(afjc_pkg::CFG_REVERSE, t_rev);
    write_reg(afjc_pkg::CFG_PAUSE, t_pause);
    write_reg(afjc_pkg::CFG_FORWARD, t_fwd);
    write_reg(afjc_pkg::CFG_MAX_TRIES, {13'd0, n_tries});
  endtask

  // runs of normal feeding, jammed auger, empty inlet and noise
  task automatic run_random(int unsigned words, int unsigned span);
    int unsigned stop_at;
    int unsigned mode;
    int unsigned left;
    int unsigned pick;
    bit          cmd;
    bit          fuel;
    bit          turn;
    logic [7:0]  target;
    stop_at = live_words + words;
    left    = 0;
    mode    = 0;
    while (live_words < stop_at) begin
      if (left == 0) begin
        pick = $urandom_range(99);
        mode = (pick < 50) ? 0 : (pick < 70) ? 1 : (pick < 85) ? 2 : 3;
        left = $urandom_range(1, span);
      end
      left--;
      cmd    = sb.resting() ? ($urandom_range(1) == 1) : ($urandom_range(99) < 2);
      target = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(1, 8));
      case (mode)
        0: begin
          fuel = 1'b1;
          turn = ($urandom_range(99) < 40);
        end
        1: begin
          fuel = 1'b1;
          turn = 1'b0;
        end
        2: begin
          fuel = 1'b0;
          turn = ($urandom_range(3) == 0);
        end
        default: begin
          cmd  = ($urandom_range(7) == 0);
          fuel = 1'($urandom_range(1));
          turn = 1'($urandom_range(1));
        end
      endcase
      send_word(cmd, fuel, turn, target);
    end
  endtask

  initial begin
    int unsigned k;
    sb              = new();
    live_words      = 0;
    tx_idle_pct     = 11;
    rx_idle_pct     = 11;
    rx_hold_req     = 0;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_cmd          <= 1'b0;
    in_fuel_ok      <= 1'b0;
    in_turn_pulse   <= 1'b0;
    in_target_turns <= 8'd0;
    cfg_valid       <= 1'b0;
    cfg_index       <= afjc_pkg::CFG_TURN_TIMEOUT;
    cfg_data        <= 16'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // shortest timings for the hand-picked cases
    write_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 3'd1);
    send_word(1'b0, 1'b1, 1'b1, 8'd255);            // tick while idle
    send_word(1'b1, 1'b1, 1'b0, 8'd0);              // target of zero
    send_word(1'b0, 1'b1, 1'b0, 8'd0);
    send_word(1'b0, 1'b1, 1'b0, 8'd0);
    send_word(1'b1, 1'b0, 1'b0, 8'd255);            // start; turn timeout leads into jam clearing
    send_word(1'b0, 1'b1, 1'b1, 8'd255);
    send_word(1'b0, 1'b1, 1'b1, 8'd255);
    send_word(1'b0, 1'b0, 1'b0, 8'd255);
    send_word(1'b0, 1'b0, 1'b1, 8'd255);
    send_word(1'b0, 1'b0, 1'b0, 8'd255);            // clearing runs forward, no fault
    send_word(1'b1, 1'b1, 1'b0, 8'd2);              // refill then settle
    send_word(1'b0, 1'b1, 1'b1, 8'd2);
    send_word(1'b0, 1'b0, 1'b0, 8'd2);
    send_word(1'b0, 1'b1, 1'b0, 8'd2);
    send_word(1'b0, 1'b1, 1'b0, 8'd2);
    send_word(1'b0, 1'b1, 1'b1, 8'd2);
    send_word(1'b1, 1'b1, 1'b0, 8'd1);              // jam clearing
    for (k = 0; k < 6; k++) send_word(1'b0, 1'b1, 1'b0, 8'd1);
    send_word(1'b0, 1'b1, 1'b1, 8'd1);
    for (k = 0; k < 3; k++) send_word(1'b0, 1'b1, 1'b0, 8'd1);
    run_random(130, 6);

    // max tries of zero, so clearing faults after the first reverse
    settle();
    write_regs(16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
               16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)), 3'd0);
    run_random(110, 10);

    // most tries; fill the block with the result side held off, then pause the sender
    settle();
    write_regs(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
               16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)), 3'd7);
    rx_hold_req = 60;
    run_random(70, 12);
    settle();
    run_random(80, 12);

    // no idling on either side
    settle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_regs(16'($urandom_range(1, 10)), 16'($urandom_range(1, 10)),
               16'($urandom_range(1, 10)), 16'($urandom_range(1, 10)),
               16'($urandom_range(1, 10)), 3'($urandom_range(1, 7)));
    run_random(150, 25);
    settle();
    tx_idle_pct = 11;
    rx_idle_pct = 11;

    // longest timings, so newly loaded timers never expire
    write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7);
    run_random(25, 4);

    settle();
    write_regs(16'($urandom_range(5, 30)), 16'($urandom_range(5, 30)),
               16'($urandom_range(5, 30)), 16'($urandom_range(5, 30)),
               16'($urandom_range(5, 30)), 3'($urandom_range(1, 7)));
    run_random(200, 80);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

@@ files.f @@
design/afjc_pkg.sv
design/afjc_step.sv
design/auger_feed_with_jam_clearing.sv
dv/auger_feed_with_jam_clearing_test.sv
